### src/ordered_list_engine_assert.svh
// Assertion macros for the ordered list engine.
// Depends on nothing; included by the top level inside its module body.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_list_engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_list_engine: next-cycle check failed");

`endif

### src/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// No dependencies; used by ole_store and ordered_list_engine.
package ole_pkg;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DEL_REAR  = 2'd1,
    OP_DEL_FRONT = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SHIFT  = 4'b0010,
    S_PUT    = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  localparam int VALUE_W = 32;
  localparam int FIELD_W = 7;

endpackage

### src/ole_store.sv
// Entry memory of the ordered list engine: one write port, one registered
// read port, and the compare of the read beat against the search key. Uses ole_pkg.
module ole_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ole_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  input  logic [ole_pkg::VALUE_W-1:0] key,
  output logic [ole_pkg::VALUE_W-1:0] rdata,
  output logic                        hit
);
  import ole_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign hit = (rdata == key);

endmodule

### src/ordered_list_engine.sv
// Ordered list engine: bounded ordered list of signed 32-bit entries.
// Command port: an operation is taken at a clock edge with start high and
// busy low. Operations are insert at a 1-based position, delete rear,
// delete front and search by value. Each operation gives exactly one result
// beat: done is high for one cycle with status, found_position and
// entry_total (the count after the operation). The receiver cannot stall;
// the beat is taken at the edge that ends the done cycle.
// Sequencing, paced by the entry memory walked one entry a cycle:
//   delete rear, and any rejected or empty-list operation: done next cycle,
//     busy never rises.
//   delete front: busy while entries shift down one slot, done follows.
//   insert at position p: busy for the shift, then the put.
//   search: busy while entries are read from the front, less when an early entry matches.
// The longest operations are a front insert into a list one short of full
// and a miss in a full list; one operation is in flight at a time. A new
// start may be taken in the cycle done is high.
// Reset clears the entry count and the sequencer; the memory contents are
// not cleared, since only positions below the count are ever read.
// Uses ole_pkg, ole_store and ordered_list_engine_assert.svh.
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [ole_pkg::VALUE_W-1:0] item_value,
  input  logic [ole_pkg::FIELD_W-1:0] insert_position,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [ole_pkg::FIELD_W-1:0] found_position,
  output logic [ole_pkg::FIELD_W-1:0] entry_total
);
  import ole_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic [CW-1:0]      n_left, n_left_next;
  logic [AW-1:0]      tgt, tgt_next;
  logic               rv, rv_next;
  logic               up, up_next;
  logic [VALUE_W-1:0] key, key_next;
  logic [AW-1:0]      pidx, pidx_next;
  logic               done_next;
  status_t            status_r, status_next;
  logic [FIELD_W-1:0] found_r, found_next;

  logic               accept;
  logic [MW-1:0]      pos_ext, cnt_ext, found_full;
  logic               bad_pos, is_full;

  logic               we, re, hit;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata, rdata;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign pos_ext = MW'(insert_position);
  assign cnt_ext = MW'(count);
  assign bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + MW'(1));
  assign is_full = (count == CW'(CAPACITY));
  assign found_full = MW'(tgt) + MW'(1);

  assign status         = status_r;
  assign found_position = found_r;
  assign entry_total    = cnt_ext[FIELD_W-1:0];

  // Memory port control: shifted beats are written in the cycle after their read.
  always_comb begin
    we    = 1'b0;
    waddr = tgt;
    wdata = rdata;
    case (state)
      S_SHIFT: begin
        we = rv;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = pidx;
        wdata = key;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign re = ((state == S_SHIFT) || (state == S_SEARCH)) && (n_left != '0);

  ole_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx),
    .key   (key),
    .rdata (rdata),
    .hit   (hit)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    n_left_next = n_left;
    tgt_next    = tgt;
    rv_next     = 1'b0;
    up_next     = up;
    key_next    = key;
    pidx_next   = pidx;
    done_next   = 1'b0;
    status_next = status_r;
    found_next  = found_r;
    case (state)
      S_IDLE: begin
        if (accept) begin
          found_next = '0;
          key_next   = item_value;
          case (opcode)
            OP_INSERT: begin
              if (bad_pos) begin
                done_next   = 1'b1;
                status_next = ST_BAD_POS;
              end else if (is_full) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else begin
                // Move entries pos-1..count-1 up one slot, highest first.
                pidx_next   = AW'(pos_ext - MW'(1));
                idx_next    = AW'(cnt_ext - MW'(1));
                n_left_next = CW'(cnt_ext - pos_ext + MW'(1));
                up_next     = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            OP_DEL_REAR: begin
              done_next = 1'b1;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                status_next = ST_OK;
                count_next  = count - CW'(1);
              end
            end
            OP_DEL_FRONT: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                idx_next    = AW'(1);
                n_left_next = count - CW'(1);
                up_next     = 1'b0;
                state_next  = S_SHIFT;
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                idx_next    = '0;
                n_left_next = count;
                state_next  = S_SEARCH;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (n_left != '0) begin
          rv_next     = 1'b1;
          tgt_next    = up ? idx + AW'(1) : idx - AW'(1);
          idx_next    = up ? idx - AW'(1) : idx + AW'(1);
          n_left_next = n_left - CW'(1);
        end else if (up) begin
          state_next = S_PUT;
        end else begin
          done_next   = 1'b1;
          status_next = ST_OK;
          count_next  = count - CW'(1);
          state_next  = S_IDLE;
        end
      end
      S_PUT: begin
        done_next   = 1'b1;
        status_next = ST_OK;
        count_next  = count + CW'(1);
        state_next  = S_IDLE;
      end
      S_SEARCH: begin
        if (rv && hit) begin
          done_next   = 1'b1;
          status_next = ST_OK;
          found_next  = found_full[FIELD_W-1:0];
          state_next  = S_IDLE;
        end else if (n_left != '0) begin
          rv_next     = 1'b1;
          tgt_next    = idx;
          idx_next    = idx + AW'(1);
          n_left_next = n_left - CW'(1);
        end else begin
          done_next   = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rv_next;
      done  <= done_next;
    end
    idx      <= idx_next;
    n_left   <= n_left_next;
    tgt      <= tgt_next;
    up       <= up_next;
    key      <= key_next;
    pidx     <= pidx_next;
    status_r <= status_next;
    found_r  <= found_next;
  end

`include "ordered_list_engine_assert.svh"

  `OLE_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `OLE_ASSERT_NEXT(a_done_needs_work, clk, rst, !busy && !start, !done)
  `OLE_ASSERT_NOW(a_found_ok, clk, rst, done && (found_position != '0), status == ST_OK)
  `OLE_ASSERT_NOW(a_full_count, clk, rst, done && (status == ST_FULL), count == CW'(CAPACITY))

endmodule

### tb/tb_ordered_list_engine.sv
// Self-checking testbench for ordered_list_engine: directed table, then random op mix.
// Depends on ole_pkg and the RTL under src; predicts result beats in-house or takes them from the directed table.
`timescale 1ns / 100ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 80;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   found_position;
    logic [FIELD_W-1:0]   entry_total;
  } outcome_t;

  typedef struct packed {
    op_t                  op;
    logic [VALUE_W-1:0]   value;
    logic [FIELD_W-1:0]   pos;
    logic                 typed;
    outcome_t             want;
  } stim_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  op_t                  opcode = OP_INSERT;
  logic [VALUE_W-1:0]   item_value = '0;
  logic [FIELD_W-1:0]   insert_position = '0;
  logic                 done;
  logic [2:0]           status;
  logic [FIELD_W-1:0]   found_position;
  logic [FIELD_W-1:0]   entry_total;

  // shadow of the list as the block should hold it
  logic [VALUE_W-1:0]   shadow_list [LIST_DEPTH];
  int                   shadow_count = 0;
  outcome_t             pending_outcomes [$];
  int                   error_count = 0;
  int                   calm_left = 0;

  localparam outcome_t NO_CHECK = '{ST_OK, 7'd0, 7'd0};

  stim_row_t directed_rows [24] = '{
    '{OP_DEL_REAR,  32'h0000_0000, 7'd0,  1'b1, '{ST_EMPTY,   7'd0, 7'd0}},
    '{OP_DEL_FRONT, 32'hFFFF_FFFF, 7'd127, 1'b1, '{ST_EMPTY,  7'd0, 7'd0}},
    '{OP_SEARCH,    32'h0000_0000, 7'd0,  1'b1, '{ST_EMPTY,   7'd0, 7'd0}},
    '{OP_INSERT,    32'h0000_0005, 7'd0,  1'b1, '{ST_BAD_POS, 7'd0, 7'd0}},
    '{OP_INSERT,    32'h0000_0005, 7'd2,  1'b1, '{ST_BAD_POS, 7'd0, 7'd0}},
    '{OP_INSERT,    32'h8000_0000, 7'd1,  1'b1, '{ST_OK,      7'd0, 7'd1}},
    '{OP_INSERT,    32'h7FFF_FFFF, 7'd2,  1'b1, '{ST_OK,      7'd0, 7'd2}},
    '{OP_INSERT,    32'hFFFF_FFFF, 7'd1,  1'b0, NO_CHECK},
    '{OP_INSERT,    32'h0000_0000, 7'd2,  1'b0, NO_CHECK},
    '{OP_INSERT,    32'h0000_0001, 7'd65, 1'b1, '{ST_BAD_POS, 7'd0, 7'd4}},
    '{OP_INSERT,    32'h0000_0001, 7'd6,  1'b0, NO_CHECK},
    '{OP_INSERT,    32'h7FFF_FFFF, 7'd5,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h7FFF_FFFF, 7'd0,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h8000_0000, 7'd64, 1'b0, NO_CHECK},
    '{OP_SEARCH,    32'hFFFF_FFFF, 7'd0,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h0000_0000, 7'd0,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h1234_5678, 7'd0,  1'b0, NO_CHECK},
    '{OP_DEL_FRONT, 32'h0000_0000, 7'd0,  1'b0, NO_CHECK},
    '{OP_DEL_REAR,  32'h0000_0000, 7'd0,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h7FFF_FFFF, 7'd0,  1'b0, NO_CHECK},
    '{OP_INSERT,    32'h55AA_55AA, 7'd3,  1'b0, NO_CHECK},
    '{OP_SEARCH,    32'h55AA_55AA, 7'd0,  1'b0, NO_CHECK},
    '{OP_DEL_REAR,  32'hAAAA_AAAA, 7'd42, 1'b0, NO_CHECK},
    '{OP_DEL_FRONT, 32'h5555_5555, 7'd21, 1'b0, NO_CHECK}
  };

  ordered_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .item_value(item_value),
    .insert_position(insert_position),
    .done(done),
    .status(status),
    .found_position(found_position),
    .entry_total(entry_total)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return the beat it should give.
  function automatic outcome_t apply_list_op(input op_t op, input logic [VALUE_W-1:0] value,
                                             input logic [FIELD_W-1:0] pos);
    outcome_t res;
    int idx;
    int p;
    res = '{ST_OK, 7'd0, 7'd0};
    p = int'(pos);
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > shadow_count + 1) begin
          res.status = ST_BAD_POS;
        end else if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (idx = shadow_count; idx > p - 1; idx--) shadow_list[idx] = shadow_list[idx-1];
          shadow_list[p-1] = value;
          shadow_count++;
        end
      end
      OP_DEL_REAR: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      OP_DEL_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (idx = 1; idx < shadow_count; idx++) shadow_list[idx-1] = shadow_list[idx];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOT_FOUND;
          for (idx = 0; idx < shadow_count; idx++) begin
            if (res.status == ST_NOT_FOUND && shadow_list[idx] == value) begin
              res.status = ST_OK;
              res.found_position = FIELD_W'(idx + 1);
            end
          end
        end
      end
    endcase
    res.entry_total = FIELD_W'(shadow_count);
    return res;
  endfunction

  // Idle cycles before the next beat; sometimes run a stretch back to back.
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Values from a small pool make duplicates, so first-match search gets exercised.
  function automatic logic [VALUE_W-1:0] draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VALUE_W'($urandom_range(0, 7)) - VALUE_W'(4);
    if (r == 4) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_op(input op_t op, input logic [VALUE_W-1:0] value,
                         input logic [FIELD_W-1:0] pos, input logic typed,
                         input outcome_t want);
    int gap;
    outcome_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    opcode          <= op;
    item_value      <= value;
    insert_position <= pos;
    do @(posedge clk); while (!(start && !busy));
    predicted = apply_list_op(op, value, pos);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic send_random_op(input mix_t mix);
    int r;
    int ins_pct;
    int del_pct;
    op_t op;
    logic [VALUE_W-1:0] value;
    logic [FIELD_W-1:0] pos;
    case (mix)
      MIX_FILL:  begin ins_pct = 80; del_pct = 8;  end
      MIX_DRAIN: begin ins_pct = 10; del_pct = 75; end
      default:   begin ins_pct = 35; del_pct = 30; end
    endcase
    r     = $urandom_range(0, 99);
    value = draw_value();
    pos   = FIELD_W'($urandom_range(0, 65));
    if (r < ins_pct) begin
      op = OP_INSERT;
      if ($urandom_range(0, 7) != 0) pos = FIELD_W'($urandom_range(1, shadow_count + 1));
      else if (shadow_count + 2 <= 65 && $urandom_range(0, 1) != 0)
        pos = FIELD_W'($urandom_range(shadow_count + 2, 65));
      else pos = '0;
    end else if (r < ins_pct + del_pct) begin
      op = ($urandom_range(0, 1) != 0) ? OP_DEL_REAR : OP_DEL_FRONT;
    end else begin
      op = OP_SEARCH;
      // mostly look for something that is there
      if (shadow_count > 0 && $urandom_range(0, 9) < 6)
        value = shadow_list[$urandom_range(0, shadow_count - 1)];
    end
    send_op(op, value, pos, 1'b0, NO_CHECK);
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d found %0d total %0d",
                 $time, status, found_position, entry_total);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (found_position !== want.found_position) begin
          $display("%0t: found_position expected %0d actual %0d",
                   $time, want.found_position, found_position);
          error_count++;
        end
        if (entry_total !== want.entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d",
                   $time, want.entry_total, entry_total);
          error_count++;
        end
      end
    end
  end

  initial begin : run_stimulus
    int waited;
    int sent;
    int seg_left;
    mix_t mix;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
              directed_rows[i].typed, directed_rows[i].want);

    // fill first so the full list shows up early, then wander between mixes
    mix      = MIX_FILL;
    seg_left = $urandom_range(90, 140);
    for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 120);
      end
      send_random_op(mix);
      seg_left--;
    end
    start <= 1'b0;

    waited = 0;
    while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_outcomes.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("** ordered_list_engine: PASSED **");
    end else begin
      $display("** ordered_list_engine: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("%0t: timeout", $time);
    $display("** ordered_list_engine: FAILED **");
    $finish;
  end

endmodule
